@@ rtl/core/dna_pkg.sv @@
// Shared types, constants and helpers for the dual-number arithmetic unit.
`timescale 1ns / 1ps
`default_nettype none
package dna_pkg;

    localparam int MAXD      = 4;                      // derivative ports
    localparam int LANES     = 4;                      // derivative lanes in use (1..MAXD)
    localparam int FRAC_BITS = 16;
    localparam int QDEPTH    = 4;
    localparam int QPTR_W    = $clog2(QDEPTH);
    localparam int DIV_NUM_W = 48;                     // widest dividend magnitude
    localparam int DIV_Q_W   = DIV_NUM_W + FRAC_BITS;  // bits shifted through the divider
    localparam int DIV_CNT_W = $clog2(DIV_Q_W);

    typedef logic signed [31:0] fx_t;
    typedef logic signed [65:0] wide_t;

    localparam fx_t   FX_MAX = 32'sh7FFF_FFFF;
    localparam fx_t   FX_MIN = 32'sh8000_0000;
    localparam wide_t W_MAX  = 66'sd2147483647;
    localparam wide_t W_MIN  = -66'sd2147483648;

    typedef enum logic [2:0] {
        FN_ADD  = 3'd0,
        FN_SUB  = 3'd1,
        FN_MUL  = 3'd2,
        FN_DIV  = 3'd3,
        FN_ADDS = 3'd4,
        FN_MULS = 3'd5,
        FN_DIVS = 3'd6,
        FN_NEG  = 3'd7
    } func_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_DIV1,
        ST_PROD,
        ST_DIV2
    } back_state_t;

    typedef struct packed {
        func_t            func;
        logic             is_div;
        fx_t              a_val;
        fx_t [MAXD-1:0]   a_d;
        fx_t              b_val;
        fx_t [MAXD-1:0]   b_d;
    } item_t;

    function automatic wide_t sx(input fx_t v);
        return $signed({{34{v[31]}}, v});
    endfunction

    function automatic wide_t ext64(input logic signed [63:0] p);
        return $signed({{2{p[63]}}, p});
    endfunction

    function automatic logic signed [63:0] mul32(input fx_t a, input fx_t b);
        return 64'(a) * 64'(b);
    endfunction

    function automatic fx_t sat32(input wide_t x);
        fx_t r;
        if (x > W_MAX)
            r = FX_MAX;
        else if (x < W_MIN)
            r = FX_MIN;
        else
            r = x[31:0];
        return r;
    endfunction

endpackage
`default_nettype wire

@@ rtl/core/dna_front.sv @@
// Front end: input register and opcode classification.
`timescale 1ns / 1ps
`default_nettype none
module dna_front import dna_pkg::*; (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           start,
    output logic           busy,
    input  logic [2:0]     func,
    input  fx_t            a_val,
    input  fx_t [MAXD-1:0] a_d,
    input  fx_t            b_val,
    input  fx_t [MAXD-1:0] b_d,
    input  logic           q_full,
    output logic           push,
    output item_t          push_item
);

    item_t in_reg, in_next;
    logic  in_vld_reg, in_vld_next;
    logic  take;

    assign busy      = in_vld_reg & q_full;
    assign push      = in_vld_reg & ~q_full;
    assign push_item = in_reg;
    assign take      = start & ~busy;

    always_comb
    begin
        in_next.func   = func_t'(func);
        in_next.is_div = (func_t'(func) == FN_DIV) || (func_t'(func) == FN_DIVS);
        in_next.a_val  = a_val;
        in_next.a_d    = a_d;
        in_next.b_val  = b_val;
        in_next.b_d    = b_d;
    end

    always_comb
    begin
        in_vld_next = in_vld_reg;
        if (push)
            in_vld_next = 1'b0;
        if (take)
            in_vld_next = 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            in_vld_reg <= 1'b0;
        else
            in_vld_reg <= in_vld_next;
    end

    always_ff @(posedge clk)
    begin
        if (take)
            in_reg <= in_next;
    end

endmodule
`default_nettype wire

@@ rtl/core/dna_queue.sv @@
// Short item queue between front and back.
`timescale 1ns / 1ps
`default_nettype none
module dna_queue import dna_pkg::*; (
    input  logic  clk,
    input  logic  rst_n,
    input  logic  push,
    input  item_t push_item,
    input  logic  pop,
    output item_t head_item,
    output logic  empty,
    output logic  full
);

    item_t             mem_reg [QDEPTH];
    logic [QPTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [QPTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [QPTR_W:0]   cnt_reg, cnt_next;

    assign empty     = (cnt_reg == '0);
    assign full      = (cnt_reg == (QPTR_W+1)'(QDEPTH));
    assign head_item = mem_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        cnt_next    = cnt_reg;
        if (push)
            wr_ptr_next = wr_ptr_reg + 1'b1;
        if (pop)
            rd_ptr_next = rd_ptr_reg + 1'b1;
        if (push && !pop)
            cnt_next = cnt_reg + 1'b1;
        else if (pop && !push)
            cnt_next = cnt_reg - 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
            mem_reg[wr_ptr_reg] <= push_item;
    end

endmodule
`default_nettype wire

@@ rtl/core/dna_div.sv @@
// Radix-2 restoring fixed-point divider with signed saturation.
`timescale 1ns / 1ps
`default_nettype none
module dna_div import dna_pkg::*; (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        start,
    input  logic signed [DIV_NUM_W-1:0] x,
    input  fx_t                         y,
    output fx_t                         q,
    output logic                        done
);

    logic [DIV_Q_W-1:0]   n_reg, n_next;
    logic [32:0]          rem_reg, rem_next;
    logic [31:0]          uy_reg, uy_next;
    logic                 neg_reg, xpos_reg, xneg_reg, yzero_reg;
    logic                 run_reg, run_next;
    logic                 done_reg, done_next;
    logic [DIV_CNT_W-1:0] cnt_reg, cnt_next;
    logic [DIV_NUM_W-1:0] ux;
    logic [32:0]          rem_sh;
    logic                 ge;
    logic                 big_pos, big_neg;

    assign ux     = x[DIV_NUM_W-1] ? (~$unsigned(x) + 1'b1) : $unsigned(x);
    assign rem_sh = {rem_reg[31:0], n_reg[DIV_Q_W-1]};
    assign ge     = (rem_sh >= {1'b0, uy_reg});
    assign done   = done_reg;

    always_comb
    begin
        n_next    = n_reg;
        rem_next  = rem_reg;
        uy_next   = uy_reg;
        run_next  = run_reg;
        cnt_next  = cnt_reg;
        done_next = 1'b0;
        if (start)
        begin
            n_next   = {ux, {FRAC_BITS{1'b0}}};
            rem_next = '0;
            uy_next  = y[31] ? (~$unsigned(y) + 1'b1) : $unsigned(y);
            run_next = 1'b1;
            cnt_next = '0;
        end
        else if (run_reg)
        begin
            rem_next = ge ? (rem_sh - {1'b0, uy_reg}) : rem_sh;
            n_next   = {n_reg[DIV_Q_W-2:0], ge};
            cnt_next = cnt_reg + 1'b1;
            if (cnt_reg == DIV_CNT_W'(DIV_Q_W - 1))
            begin
                run_next  = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            run_reg  <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            run_reg  <= run_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        n_reg   <= n_next;
        rem_reg <= rem_next;
        uy_reg  <= uy_next;
        if (start)
        begin
            neg_reg   <= x[DIV_NUM_W-1] ^ y[31];
            xpos_reg  <= !x[DIV_NUM_W-1] && (x != '0);
            xneg_reg  <= x[DIV_NUM_W-1];
            yzero_reg <= (y == '0);
        end
    end

    // quotient above 2^31 saturates either way
    assign big_pos = |n_reg[DIV_Q_W-1:31];
    assign big_neg = (|n_reg[DIV_Q_W-1:32]) | (n_reg[31] & (|n_reg[30:0]));

    always_comb
    begin
        if (yzero_reg)
            q = xpos_reg ? FX_MAX : (xneg_reg ? FX_MIN : '0);
        else if (neg_reg)
            q = big_neg ? FX_MIN : fx_t'(~n_reg[31:0] + 1'b1);
        else
            q = big_pos ? FX_MAX : fx_t'(n_reg[31:0]);
    end

endmodule
`default_nettype wire

@@ rtl/core/dna_back.sv @@
// Back end: multiply pipeline, divide sequencer and result register.
`timescale 1ns / 1ps
`default_nettype none
module dna_back import dna_pkg::*; (
    input  logic           clk,
    input  logic           rst_n,
    input  item_t          head_item,
    input  logic           empty,
    output logic           pop,
    output logic           valid,
    output fx_t            r_val,
    output fx_t [MAXD-1:0] r_d,
    output logic           div_zero
);

    back_state_t state_reg, state_next;

    // simple-op pipeline stage
    logic               s1_vld_reg;
    item_t              s1_reg;
    logic signed [63:0] p_vv_reg;
    logic signed [63:0] p_ab_reg [MAXD];
    logic signed [63:0] p_ba_reg [MAXD];

    // divide operands
    func_t              dfunc_reg;
    fx_t                dbv_reg;
    fx_t                dad_reg [MAXD];
    fx_t                dbd_reg [MAXD];
    logic signed [63:0] prod_reg [MAXD];

    // result register
    logic           valid_reg, valid_next;
    fx_t            r_val_reg, r_val_next;
    fx_t [MAXD-1:0] r_d_reg, r_d_next;
    logic           dz_reg, dz_next;

    logic                        start1, start2;
    logic                        val_done;
    fx_t                         q_val;
    logic                        lane_done [MAXD];
    fx_t                         lane_q    [MAXD];
    logic signed [DIV_NUM_W-1:0] lane_x    [MAXD];
    fx_t                         lane_y;
    logic signed [DIV_NUM_W-1:0] t_val     [MAXD];

    assign pop    = !empty && (state_reg == ST_IDLE);
    assign start1 = pop && head_item.is_div;
    assign start2 = (state_reg == ST_PROD);
    assign lane_y = start1 ? head_item.b_val : dbv_reg;

    assign valid    = valid_reg;
    assign r_val    = r_val_reg;
    assign r_d      = r_d_reg;
    assign div_zero = dz_reg;

    dna_div u_div_val (
        .clk   (clk),
        .rst_n (rst_n),
        .start (start1),
        .x     ($signed({{(DIV_NUM_W-32){head_item.a_val[31]}}, head_item.a_val})),
        .y     (head_item.b_val),
        .q     (q_val),
        .done  (val_done)
    );

    for (genvar i = 0; i < MAXD; i++)
    begin : g_lane
        // t = a_di - floor(q * b_di / 2^F); fits 48 bits
        assign t_val[i] = $signed({{(DIV_NUM_W-32){dad_reg[i][31]}}, dad_reg[i]})
                        - $signed(prod_reg[i][63:FRAC_BITS]);
        assign lane_x[i] = start1
                         ? $signed({{(DIV_NUM_W-32){head_item.a_d[i][31]}}, head_item.a_d[i]})
                         : t_val[i];

        dna_div u_div_lane (
            .clk   (clk),
            .rst_n (rst_n),
            .start (start1 || start2),
            .x     (lane_x[i]),
            .y     (lane_y),
            .q     (lane_q[i]),
            .done  (lane_done[i])
        );
    end

    // sequencer and result selection
    always_comb
    begin
        state_next = state_reg;
        valid_next = 1'b0;
        r_val_next = r_val_reg;
        r_d_next   = r_d_reg;
        dz_next    = 1'b0;

        if (s1_vld_reg)
        begin
            valid_next = 1'b1;
            unique case (s1_reg.func)
                FN_ADD:
                begin
                    r_val_next = sat32(sx(s1_reg.b_val) + sx(s1_reg.a_val));
                    for (int i = 0; i < MAXD; i++)
                        r_d_next[i] = sat32(sx(s1_reg.a_d[i]) + sx(s1_reg.b_d[i]));
                end
                FN_SUB:
                begin
                    r_val_next = sat32(sx(s1_reg.a_val) - sx(s1_reg.b_val));
                    for (int i = 0; i < MAXD; i++)
                        r_d_next[i] = sat32(sx(s1_reg.a_d[i]) - sx(s1_reg.b_d[i]));
                end
                FN_MUL:
                begin
                    r_val_next = sat32(ext64(p_vv_reg) >>> FRAC_BITS);
                    for (int i = 0; i < MAXD; i++)
                        r_d_next[i] = sat32((ext64(p_ab_reg[i]) + ext64(p_ba_reg[i]))
                                            >>> FRAC_BITS);
                end
                FN_ADDS:
                begin
                    r_val_next = sat32(sx(s1_reg.a_val) + sx(s1_reg.b_val));
                    for (int i = 0; i < MAXD; i++)
                        r_d_next[i] = s1_reg.a_d[i];
                end
                FN_MULS:
                begin
                    r_val_next = sat32(ext64(p_vv_reg) >>> FRAC_BITS);
                    for (int i = 0; i < MAXD; i++)
                        r_d_next[i] = sat32(ext64(p_ba_reg[i]) >>> FRAC_BITS);
                end
                FN_NEG:
                begin
                    r_val_next = sat32(-sx(s1_reg.a_val));
                    for (int i = 0; i < MAXD; i++)
                        r_d_next[i] = sat32(-sx(s1_reg.a_d[i]));
                end
                default:
                begin
                    r_val_next = '0;
                    r_d_next   = '0;
                end
            endcase
        end

        unique case (state_reg)
            ST_IDLE:
            begin
                if (start1)
                    state_next = ST_DIV1;
            end
            ST_DIV1:
            begin
                if (val_done)
                begin
                    if (dfunc_reg == FN_DIVS)
                    begin
                        valid_next = 1'b1;
                        r_val_next = q_val;
                        for (int i = 0; i < MAXD; i++)
                            r_d_next[i] = lane_q[i];
                        dz_next    = (dbv_reg == '0);
                        state_next = ST_IDLE;
                    end
                    else
                        state_next = ST_PROD;
                end
            end
            ST_PROD:
            begin
                state_next = ST_DIV2;
            end
            ST_DIV2:
            begin
                if (lane_done[0])
                begin
                    valid_next = 1'b1;
                    r_val_next = q_val;
                    for (int i = 0; i < MAXD; i++)
                        r_d_next[i] = lane_q[i];
                    dz_next    = (dbv_reg == '0);
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase

        for (int i = LANES; i < MAXD; i++)
            r_d_next[i] = '0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= ST_IDLE;
            s1_vld_reg <= 1'b0;
            valid_reg  <= 1'b0;
            dz_reg     <= 1'b0;
        end
        else
        begin
            state_reg  <= state_next;
            s1_vld_reg <= pop && !head_item.is_div;
            valid_reg  <= valid_next;
            dz_reg     <= dz_next;
        end
    end

    always_ff @(posedge clk)
    begin
        r_val_reg <= r_val_next;
        r_d_reg   <= r_d_next;
        if (pop)
        begin
            s1_reg   <= head_item;
            p_vv_reg <= mul32(head_item.a_val, head_item.b_val);
            for (int i = 0; i < MAXD; i++)
            begin
                p_ab_reg[i] <= mul32(head_item.a_val, head_item.b_d[i]);
                p_ba_reg[i] <= mul32(head_item.b_val, head_item.a_d[i]);
            end
        end
        if (start1)
        begin
            dfunc_reg <= head_item.func;
            dbv_reg   <= head_item.b_val;
            for (int i = 0; i < MAXD; i++)
            begin
                dad_reg[i] <= head_item.a_d[i];
                dbd_reg[i] <= head_item.b_d[i];
            end
        end
        if (state_reg == ST_DIV1 && val_done)
        begin
            for (int i = 0; i < MAXD; i++)
                prod_reg[i] <= mul32(q_val, dbd_reg[i]);
        end
    end

    // a simple-op result must never meet a divide result
    a_no_collide: assert property (@(posedge clk) disable iff (!rst_n)
        s1_vld_reg |-> !((state_reg == ST_DIV2) && lane_done[0]))
        else $error("simple and divide results collide");

    a_dz_marked: assert property (@(posedge clk) disable iff (!rst_n)
        dz_reg |-> valid_reg)
        else $error("div_zero without result strobe");

    a_div_enter: assert property (@(posedge clk) disable iff (!rst_n)
        start1 |=> (state_reg == ST_DIV1))
        else $error("divide item did not enter sequencer");

    a_val_done: assert property (@(posedge clk) disable iff (!rst_n)
        val_done |-> (state_reg == ST_DIV1))
        else $error("value divider finished outside first pass");

endmodule
`default_nettype wire

@@ rtl/core/dual_number_alu.sv @@
// Top level of the dual-number arithmetic unit.
//
// Usage:
//   Command channel: drive func and the operand ports and raise start; the
//   item is taken at a rising edge where start is high and busy is low.
//   Result channel: valid is high for one cycle with r_val, r_d0..r_d3 and
//   div_zero; the receiver must take it then, there is no backpressure.
// Structure: an input register feeds a 4-entry item queue; the back end
//   pops it, runs add/sub/negate/products through a two-stage multiply
//   pipeline, and runs quotients on five radix-2 dividers (value + lanes).
// Throughput:
//   add, sub, mul, add/mul scalar, negate: one item per cycle while no
//   divide is running in the back end.
//   divide by scalar: one 64-step divider pass.
//   quotient rule: two divider passes plus a product step.
//   Items behind a divide wait in the queue; busy rises once the queue and
//   the input register are full.
// Reset: rst_n clears the queue, the sequencer and valid; no result is
//   pending afterward.
`timescale 1ns / 1ps
`default_nettype none
module dual_number_alu import dna_pkg::*; (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       start,
    output logic       busy,
    input  logic [2:0] func,
    input  fx_t        a_val,
    input  fx_t        a_d0,
    input  fx_t        a_d1,
    input  fx_t        a_d2,
    input  fx_t        a_d3,
    input  fx_t        b_val,
    input  fx_t        b_d0,
    input  fx_t        b_d1,
    input  fx_t        b_d2,
    input  fx_t        b_d3,
    output logic       valid,
    output fx_t        r_val,
    output fx_t        r_d0,
    output fx_t        r_d1,
    output fx_t        r_d2,
    output fx_t        r_d3,
    output logic       div_zero
);

    fx_t [MAXD-1:0] a_d_in;
    fx_t [MAXD-1:0] b_d_in;
    fx_t [MAXD-1:0] r_d_out;
    item_t          push_item;
    item_t          head_item;
    logic           push, pop, q_empty, q_full;

    assign a_d_in = {a_d3, a_d2, a_d1, a_d0};
    assign b_d_in = {b_d3, b_d2, b_d1, b_d0};

    // front: registers the item and tags divides
    dna_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (start),
        .busy      (busy),
        .func      (func),
        .a_val     (a_val),
        .a_d       (a_d_in),
        .b_val     (b_val),
        .b_d       (b_d_in),
        .q_full    (q_full),
        .push      (push),
        .push_item (push_item)
    );

    // decoupling queue
    dna_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_item (push_item),
        .pop       (pop),
        .head_item (head_item),
        .empty     (q_empty),
        .full      (q_full)
    );

    // back: execution and result register
    dna_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .head_item (head_item),
        .empty     (q_empty),
        .pop       (pop),
        .valid     (valid),
        .r_val     (r_val),
        .r_d       (r_d_out),
        .div_zero  (div_zero)
    );

    assign r_d0 = r_d_out[0];
    assign r_d1 = r_d_out[1];
    assign r_d2 = r_d_out[2];
    assign r_d3 = r_d_out[3];

endmodule
`default_nettype wire
